// ----- rtl/lmx_pkg.sv -----
`default_nettype none
package lmx_pkg;

    // sizes
    localparam int MAX_PROCS  = 16;
    localparam int CLOCK_BITS = 32;
    localparam int PID_W      = $clog2(MAX_PROCS);
    localparam int CNT_W      = $clog2(MAX_PROCS + 1);
    localparam int CFG_W      = 5;

    localparam logic [CNT_W-1:0]      CNT_MAX   = CNT_W'(MAX_PROCS);
    localparam logic [CLOCK_BITS-1:0] CLOCK_MAX = {CLOCK_BITS{1'b1}};

    // configuration register indexes
    localparam logic CFG_PROCESS_COUNT = 1'b0;
    localparam logic CFG_OWN_RANK      = 1'b1;

    // incoming word codes
    typedef enum logic [2:0] {
        OP_OK      = 3'd0,
        OP_REQUIRE = 3'd1,
        OP_RELEASE = 3'd2,
        OP_FINISH  = 3'd3,
        OP_LOCK    = 3'd4,
        OP_UNLOCK  = 3'd5,
        OP_STOP    = 3'd6
    } t_opcode;

    // outgoing word codes
    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_OK_REPLY = 3'd1,
        ACT_REQUIRE  = 3'd2,
        ACT_RELEASE  = 3'd3,
        ACT_FINISH   = 3'd4
    } t_action;

    // one queue entry
    typedef struct packed {
        logic [CLOCK_BITS-1:0] stamp;
        logic [PID_W-1:0]      pid;
    } t_entry;

    // command broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry key;
    } t_qcmd;

    // queue status back to the controller
    typedef struct packed {
        logic             full;
        logic             next_nonempty;
        logic [PID_W-1:0] next_head_pid;
    } t_qstat;

endpackage
`default_nettype wire

// ----- rtl/lmx_cell.sv -----
`default_nettype none
module lmx_cell (
    input  wire logic           i_clk,
    input  wire logic           i_occ,
    input  wire lmx_pkg::t_qcmd i_cmd,
    input  wire lmx_pkg::t_entry i_left,
    input  wire logic           i_left_le,
    input  wire lmx_pkg::t_entry i_right,
    input  wire logic           i_hit_in,
    output lmx_pkg::t_entry     o_entry,
    output lmx_pkg::t_entry     o_next,
    output logic                o_le,
    output logic                o_hit_out
);

    lmx_pkg::t_entry r_entry;
    lmx_pkg::t_entry n_entry;
    logic            match;

    // order compare: this entry sorts at or before the key
    assign o_le = i_occ && ((r_entry.stamp < i_cmd.key.stamp) ||
                            ((r_entry.stamp == i_cmd.key.stamp) &&
                             (r_entry.pid <= i_cmd.key.pid)));

    // first-match chain for removal
    assign match     = i_occ && (r_entry.pid == i_cmd.key.pid);
    assign o_hit_out = i_hit_in || match;

    // insert shifts right, removal shifts left
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins) begin
            if (o_le) begin
                n_entry = r_entry;
            end else if (i_left_le) begin
                n_entry = i_cmd.key;
            end else begin
                n_entry = i_left;
            end
        end else if (i_cmd.rem && o_hit_out) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_next  = n_entry;

endmodule
`default_nettype wire

// ----- rtl/lmx_queue.sv -----
`default_nettype none
module lmx_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire lmx_pkg::t_qcmd i_cmd,
    output lmx_pkg::t_qstat     o_stat
);

    localparam int N = lmx_pkg::MAX_PROCS;

    logic [lmx_pkg::CNT_W-1:0] r_fill;
    logic [lmx_pkg::CNT_W-1:0] n_fill;

    lmx_pkg::t_entry entry [N];
    lmx_pkg::t_entry nxt   [N];
    logic [N-1:0]    le;
    logic [N-1:0]    hit;
    logic            full;
    logic            ins_ok;

    assign full   = (r_fill == lmx_pkg::CNT_MAX);
    assign ins_ok = i_cmd.ins && !full;

    // row of cells, neighbors wired left and right
    for (genvar g = 0; g < N; g++) begin : g_cell
        lmx_pkg::t_qcmd  cmd;
        lmx_pkg::t_entry left;
        lmx_pkg::t_entry right;
        logic            left_le;
        logic            hit_in;

        always_comb begin
            cmd     = i_cmd;
            cmd.ins = ins_ok;
        end

        if (g == 0) begin : g_head
            assign left    = i_cmd.key;
            assign left_le = 1'b1;
            assign hit_in  = 1'b0;
        end else begin : g_body
            assign left    = entry[g-1];
            assign left_le = le[g-1];
            assign hit_in  = hit[g-1];
        end

        if (g == N - 1) begin : g_tail
            assign right = entry[g];
        end else begin : g_inner
            assign right = entry[g+1];
        end

        lmx_cell u_cell (
            .i_clk     (i_clk),
            .i_occ     (lmx_pkg::CNT_W'(g) < r_fill),
            .i_cmd     (cmd),
            .i_left    (left),
            .i_left_le (left_le),
            .i_right   (right),
            .i_hit_in  (hit_in),
            .o_entry   (entry[g]),
            .o_next    (nxt[g]),
            .o_le      (le[g]),
            .o_hit_out (hit[g])
        );
    end

    // fill count
    always_comb begin
        n_fill = r_fill;
        if (ins_ok) begin
            n_fill = r_fill + 1'b1;
        end else if (i_cmd.rem && hit[N-1]) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    assign o_stat.full          = full;
    assign o_stat.next_nonempty = (n_fill != '0);
    assign o_stat.next_head_pid = nxt[0].pid;

endmodule
`default_nettype wire

// ----- rtl/lmx_top_dummy_placeholder.sv -----
`default_nettype none
module lmx_sat_inc (
    input  wire logic [lmx_pkg::CLOCK_BITS-1:0] i_base,
    output logic      [lmx_pkg::CLOCK_BITS-1:0] o_next
);

    // saturating increment of the logical clock
    assign o_next = (i_base == lmx_pkg::CLOCK_MAX) ? i_base : i_base + 1'b1;

endmodule
`default_nettype wire

// ----- rtl/lamport_mutex_node_core.sv -----
`default_nettype none
// channel   direction  handshake             payload
// command   in         start & !busy         i_opcode, i_msg_clock, i_msg_source
// result    out        o_strobe, one cycle   o_send_action, o_send_dest, o_send_clock,
//                                            o_grant, o_all_finished, o_queue_overflow
// config    in         i_cfg_we              i_cfg_idx, i_cfg_data
//
// one word per cycle: busy stays low, every accepted word gives its result
// on the next cycle with o_strobe high for that single cycle
// the figure is set by the queue cells, which compare and shift all entries
// in parallel in the accepting cycle
// synchronous active-low reset clears clock, ok counter, fill and finished flag, sets alive mask
// the receiver cannot stall, so results are never held
module lamport_mutex_node_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [2:0]                      i_opcode,
    input  wire logic [lmx_pkg::CLOCK_BITS-1:0]  i_msg_clock,
    input  wire logic [lmx_pkg::PID_W-1:0]       i_msg_source,
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_idx,
    input  wire logic [lmx_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                                 o_strobe,
    output logic [2:0]                           o_send_action,
    output logic [lmx_pkg::PID_W-1:0]            o_send_dest,
    output logic [lmx_pkg::CLOCK_BITS-1:0]       o_send_clock,
    output logic                                 o_grant,
    output logic                                 o_all_finished,
    output logic                                 o_queue_overflow
);

    localparam int N = lmx_pkg::MAX_PROCS;

    // state
    logic [lmx_pkg::CNT_W-1:0]      r_proc_cnt;
    logic [lmx_pkg::PID_W-1:0]      r_own_rank;
    logic [lmx_pkg::CLOCK_BITS-1:0] r_clock, n_clock;
    logic [lmx_pkg::CNT_W-1:0]      r_ok, n_ok;
    logic [N-1:0]                   r_alive, n_alive;
    logic                           r_finished, n_finished;

    // result registers
    logic                           r_strobe;
    lmx_pkg::t_action               r_action, n_action;
    logic [lmx_pkg::PID_W-1:0]      r_dest, n_dest;
    logic [lmx_pkg::CLOCK_BITS-1:0] r_sclk, n_sclk;
    logic                           r_grant, n_grant;
    logic                           r_fin_out;
    logic                           r_ovf, n_ovf;

    logic                           accept;
    lmx_pkg::t_opcode               op;
    logic                           recv;
    logic                           local_cmd;
    logic [lmx_pkg::CLOCK_BITS-1:0] base;
    logic [lmx_pkg::CLOCK_BITS-1:0] ticked;
    logic [lmx_pkg::CNT_W-1:0]      eff_cnt;
    logic [N-1:0]                   eff_mask;
    lmx_pkg::t_qcmd                 qcmd;
    lmx_pkg::t_qstat                qstat;

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign op        = lmx_pkg::t_opcode'(i_opcode);
    assign recv      = (i_opcode <= 3'(lmx_pkg::OP_FINISH)) && !r_finished;
    assign local_cmd = (op == lmx_pkg::OP_LOCK) || (op == lmx_pkg::OP_UNLOCK) ||
                       (op == lmx_pkg::OP_STOP);

    // clock merge and tick
    assign base = (recv && (i_msg_clock > r_clock)) ? i_msg_clock : r_clock;

    lmx_sat_inc u_inc (
        .i_base (base),
        .o_next (ticked)
    );

    // live process window
    assign eff_cnt = (r_proc_cnt > lmx_pkg::CNT_MAX) ? lmx_pkg::CNT_MAX : r_proc_cnt;
    always_comb begin
        for (int i = 0; i < N; i++) begin
            eff_mask[i] = lmx_pkg::CNT_W'(i) < eff_cnt;
        end
    end

    // queue command
    always_comb begin
        qcmd.ins       = accept && recv && (op == lmx_pkg::OP_REQUIRE);
        qcmd.rem       = accept && recv && (op == lmx_pkg::OP_RELEASE);
        qcmd.key.stamp = i_msg_clock;
        qcmd.key.pid   = i_msg_source;
    end

    lmx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (qcmd),
        .o_stat  (qstat)
    );

    // step decode
    always_comb begin
        n_clock    = r_clock;
        n_ok       = r_ok;
        n_alive    = r_alive;
        n_finished = r_finished;
        n_action   = lmx_pkg::ACT_NONE;
        n_dest     = '0;
        n_sclk     = '0;
        n_ovf      = 1'b0;
        if (recv) begin
            n_clock = ticked;
            case (op)
                lmx_pkg::OP_OK: begin
                    if (r_ok < lmx_pkg::CNT_MAX) begin
                        n_ok = r_ok + 1'b1;
                    end
                end
                lmx_pkg::OP_REQUIRE: begin
                    n_ovf    = qstat.full;
                    n_action = lmx_pkg::ACT_OK_REPLY;
                    n_dest   = i_msg_source;
                    n_sclk   = ticked;
                end
                lmx_pkg::OP_FINISH: begin
                    n_alive    = r_alive & ~(N'(1) << i_msg_source);
                    n_finished = ((n_alive & eff_mask) == '0);
                end
                default: begin
                    n_clock = ticked;
                end
            endcase
        end else if (local_cmd) begin
            n_clock = ticked;
            n_sclk  = ticked;
            case (op)
                lmx_pkg::OP_LOCK: begin
                    n_ok     = '0;
                    n_action = lmx_pkg::ACT_REQUIRE;
                end
                lmx_pkg::OP_UNLOCK: begin
                    n_action = lmx_pkg::ACT_RELEASE;
                end
                default: begin
                    n_action = lmx_pkg::ACT_FINISH;
                end
            endcase
        end
        n_grant = (n_ok == r_proc_cnt) && qstat.next_nonempty &&
                  (qstat.next_head_pid == r_own_rank);
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proc_cnt <= lmx_pkg::CNT_W'(1);
            r_own_rank <= '0;
            r_clock    <= '0;
            r_ok       <= '0;
            r_alive    <= '1;
            r_finished <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == lmx_pkg::CFG_PROCESS_COUNT) begin
                    r_proc_cnt <= i_cfg_data[lmx_pkg::CNT_W-1:0];
                end else begin
                    r_own_rank <= i_cfg_data[lmx_pkg::PID_W-1:0];
                end
            end
            if (accept) begin
                r_clock    <= n_clock;
                r_ok       <= n_ok;
                r_alive    <= n_alive;
                r_finished <= n_finished;
            end
            r_strobe <= accept;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action  <= n_action;
            r_dest    <= n_dest;
            r_sclk    <= n_sclk;
            r_grant   <= n_grant;
            r_fin_out <= n_finished;
            r_ovf     <= n_ovf;
        end
    end

    assign o_strobe         = r_strobe;
    assign o_send_action    = r_action;
    assign o_send_dest      = r_dest;
    assign o_send_clock     = r_sclk;
    assign o_grant          = r_grant;
    assign o_all_finished   = r_fin_out;
    assign o_queue_overflow = r_ovf;

`ifndef SYNTHESIS
    // every accepted word yields exactly one result next cycle
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_strobe)
        else $error("result strobe missing after accept");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_strobe)
        else $error("result strobe without accepted word");

    // finished is sticky
    a_fin_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |=> r_finished)
        else $error("finished flag dropped");

    // a dropped request still gets its ok reply
    a_ovf_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_queue_overflow) |-> (o_send_action == lmx_pkg::ACT_OK_REPLY))
        else $error("overflow without ok reply");

    // silent results carry no clock
    a_quiet_clock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_send_action == lmx_pkg::ACT_NONE)) |-> (o_send_clock == '0))
        else $error("clock sent with no action");
`endif

endmodule
`default_nettype wire

// ----- tb/lamport_mutex_node_core_checker.sv -----
// watches the command, config and result channels of the mutex node,
// keeps its own copy of the node state and checks every result word
module lamport_mutex_node_core_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic                            i_busy,
    input  wire logic [2:0]                      i_opcode,
    input  wire logic [lmx_pkg::CLOCK_BITS-1:0]  i_msg_clock,
    input  wire logic [lmx_pkg::PID_W-1:0]       i_msg_source,
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_idx,
    input  wire logic [lmx_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire logic                            i_strobe,
    input  wire logic [2:0]                      i_send_action,
    input  wire logic [lmx_pkg::PID_W-1:0]       i_send_dest,
    input  wire logic [lmx_pkg::CLOCK_BITS-1:0]  i_send_clock,
    input  wire logic                            i_grant,
    input  wire logic                            i_all_finished,
    input  wire logic                            i_queue_overflow,
    output int                                   o_mismatches,
    output int                                   o_pending,
    output int                                   o_checked,
    output int                                   o_grants,
    output int                                   o_overflows
);
    import lmx_pkg::*;

    // one outgoing word as the node should produce it
    typedef struct packed {
        t_action               action;
        logic [PID_W-1:0]      dest;
        logic [CLOCK_BITS-1:0] stamp;
        logic                  grant;
        logic                  all_done;
        logic                  overflow;
    } t_reply;

    t_reply pending_replies[$];

    // shadow of the node registers and state
    logic [CFG_W-1:0]      proc_count;
    logic [PID_W-1:0]      own_rank;
    logic [CLOCK_BITS-1:0] node_clock;
    logic [CNT_W-1:0]      ok_count;
    logic [CLOCK_BITS-1:0] slot_stamp [MAX_PROCS];
    logic [PID_W-1:0]      slot_pid   [MAX_PROCS];
    int                    slot_fill;
    logic [MAX_PROCS-1:0]  alive_mask;
    logic                  finished;

    int mismatch_count;
    int checked_count;
    int grant_count;
    int overflow_count;

    function automatic logic [CLOCK_BITS-1:0] saturating_tick(input logic [CLOCK_BITS-1:0] v);
        return (v == CLOCK_MAX) ? v : v + 1'b1;
    endfunction

    // advance the shadow state by one command word and build its reply
    task automatic predict_reply(input logic [2:0] op, input logic [CLOCK_BITS-1:0] mclk,
                                 input logic [PID_W-1:0] src, output t_reply r);
        int pos;
        int i;
        int n;
        r = '0;
        r.action = ACT_NONE;
        case (op)
            OP_OK, OP_REQUIRE, OP_RELEASE, OP_FINISH: begin
                // received words are dropped once every process is done
                if (!finished) begin
                    if (mclk > node_clock) begin
                        node_clock = mclk;
                    end
                    node_clock = saturating_tick(node_clock);
                    case (op)
                        OP_OK: begin
                            if (ok_count < CNT_MAX) begin
                                ok_count = ok_count + 1'b1;
                            end
                        end
                        OP_REQUIRE: begin
                            // sorted insert by (stamp, pid), ties go behind
                            if (slot_fill >= MAX_PROCS) begin
                                r.overflow = 1'b1;
                            end else begin
                                pos = 0;
                                while (pos < slot_fill && (slot_stamp[pos] < mclk ||
                                       (slot_stamp[pos] == mclk && slot_pid[pos] <= src))) begin
                                    pos++;
                                end
                                for (i = slot_fill; i > pos; i--) begin
                                    slot_stamp[i] = slot_stamp[i-1];
                                    slot_pid[i]   = slot_pid[i-1];
                                end
                                slot_stamp[pos] = mclk;
                                slot_pid[pos]   = src;
                                slot_fill++;
                            end
                            r.action = ACT_OK_REPLY;
                            r.dest   = src;
                            r.stamp  = node_clock;
                        end
                        OP_RELEASE: begin
                            // first entry of that sender leaves, if any
                            pos = 0;
                            while (pos < slot_fill && slot_pid[pos] != src) begin
                                pos++;
                            end
                            if (pos < slot_fill) begin
                                for (i = pos; i + 1 < slot_fill; i++) begin
                                    slot_stamp[i] = slot_stamp[i+1];
                                    slot_pid[i]   = slot_pid[i+1];
                                end
                                slot_fill--;
                            end
                        end
                        default: begin
                            alive_mask[src] = 1'b0;
                            n = (proc_count > MAX_PROCS) ? MAX_PROCS : int'(proc_count);
                            finished = 1'b1;
                            for (i = 0; i < n; i++) begin
                                if (alive_mask[i]) begin
                                    finished = 1'b0;
                                end
                            end
                        end
                    endcase
                end
            end
            OP_LOCK, OP_UNLOCK, OP_STOP: begin
                if (op == OP_LOCK) begin
                    ok_count = '0;
                end
                node_clock = saturating_tick(node_clock);
                case (op)
                    OP_LOCK:   r.action = ACT_REQUIRE;
                    OP_UNLOCK: r.action = ACT_RELEASE;
                    default:   r.action = ACT_FINISH;
                endcase
                r.stamp = node_clock;
            end
            default: begin
            end
        endcase
        r.grant    = (ok_count == proc_count) && (slot_fill > 0) && (slot_pid[0] == own_rank);
        r.all_done = finished;
    endtask

    // compare, track config, predict on every rising edge
    always @(posedge i_clk) begin : watch
        t_reply want;
        logic   bad;
        if (!i_rst_n) begin
            proc_count = 5'd1;
            own_rank   = '0;
            node_clock = '0;
            ok_count   = '0;
            slot_fill  = 0;
            alive_mask = '1;
            finished   = 1'b0;
            pending_replies.delete();
            mismatch_count = 0;
            checked_count  = 0;
            grant_count    = 0;
            overflow_count = 0;
        end else begin
            // result word against the oldest prediction
            if (i_strobe === 1'b1) begin
                if (pending_replies.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: result word with no command outstanding, action %0d",
                                 $realtime, i_send_action);
                    end
                end else begin
                    want = pending_replies.pop_front();
                    checked_count++;
                    bad = (i_send_action !== want.action) || (i_send_dest !== want.dest) ||
                          (i_send_clock !== want.stamp) || (i_grant !== want.grant) ||
                          (i_all_finished !== want.all_done) ||
                          (i_queue_overflow !== want.overflow);
                    if (bad) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: expected action %0d dest %0d clock %h grant %b done %b ovf %b",
                                     $realtime, want.action, want.dest, want.stamp, want.grant,
                                     want.all_done, want.overflow);
                            $display("%0t: actual   action %0d dest %0d clock %h grant %b done %b ovf %b",
                                     $realtime, i_send_action, i_send_dest, i_send_clock, i_grant,
                                     i_all_finished, i_queue_overflow);
                        end
                    end
                end
            end
            // register writes
            if (i_cfg_we === 1'b1) begin
                case (i_cfg_idx)
                    CFG_PROCESS_COUNT: proc_count = i_cfg_data;
                    CFG_OWN_RANK:      own_rank   = i_cfg_data[PID_W-1:0];
                    default: begin
                    end
                endcase
            end
            // accepted command word
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                predict_reply(i_opcode, i_msg_clock, i_msg_source, want);
                if (want.grant) begin
                    grant_count++;
                end
                if (want.overflow) begin
                    overflow_count++;
                end
                pending_replies.push_back(want);
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= pending_replies.size();
        o_checked    <= checked_count;
        o_grants     <= grant_count;
        o_overflows  <= overflow_count;
    end

endmodule

// ----- tb/lamport_mutex_node_core_tb.sv -----
// stimulus and verdict for the mutex node; checking lives in the checker
module lamport_mutex_node_core_tb;
    import lmx_pkg::*;

    localparam logic [2:0] OP_SPARE    = 3'd7;
    localparam int         STALL_LIMIT = 2000;

    typedef struct packed {
        logic [2:0]            op;
        logic [CLOCK_BITS-1:0] stamp;
        logic [PID_W-1:0]      src;
    } t_cmd;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [2:0]            i_opcode;
    logic [CLOCK_BITS-1:0] i_msg_clock;
    logic [PID_W-1:0]      i_msg_source;
    logic                  i_cfg_we;
    logic                  i_cfg_idx;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  o_strobe;
    logic [2:0]            o_send_action;
    logic [PID_W-1:0]      o_send_dest;
    logic [CLOCK_BITS-1:0] o_send_clock;
    logic                  o_grant;
    logic                  o_all_finished;
    logic                  o_queue_overflow;

    int mismatches;
    int pending_count;
    int checked;
    int grants;
    int overflows;

    // stimulus bookkeeping
    t_cmd                  batch[$];
    logic [CLOCK_BITS-1:0] stamp_hint;
    logic [CFG_W-1:0]      cur_pc;
    logic [PID_W-1:0]      cur_rank;
    bit                    wide_stamps;
    bit                    no_gaps;
    int                    gap_run;
    int                    items_sent;
    int                    settings_used;
    int                    idle_cycles;

    always #5 i_clk = ~i_clk;

    lamport_mutex_node_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_msg_clock      (i_msg_clock),
        .i_msg_source     (i_msg_source),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_strobe         (o_strobe),
        .o_send_action    (o_send_action),
        .o_send_dest      (o_send_dest),
        .o_send_clock     (o_send_clock),
        .o_grant          (o_grant),
        .o_all_finished   (o_all_finished),
        .o_queue_overflow (o_queue_overflow)
    );

    lamport_mutex_node_core_checker node_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_opcode         (i_opcode),
        .i_msg_clock      (i_msg_clock),
        .i_msg_source     (i_msg_source),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_strobe         (o_strobe),
        .i_send_action    (o_send_action),
        .i_send_dest      (o_send_dest),
        .i_send_clock     (o_send_clock),
        .i_grant          (o_grant),
        .i_all_finished   (o_all_finished),
        .i_queue_overflow (o_queue_overflow),
        .o_mismatches     (mismatches),
        .o_pending        (pending_count),
        .o_checked        (checked),
        .o_grants         (grants),
        .o_overflows      (overflows)
    );

    // watchdog: cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (start === 1'b1 && busy === 1'b0) || o_strobe === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // timestamp near the running hint, with ties, stale and wide values
    function automatic logic [CLOCK_BITS-1:0] pick_stamp();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (wide_stamps && roll < 3) begin
            return $urandom();
        end
        if (roll < 5) begin
            return stamp_hint;
        end
        if (roll < 7 && stamp_hint > 4) begin
            return stamp_hint - $urandom_range(1, 4);
        end
        return stamp_hint + $urandom_range(1, 4);
    endfunction

    // finish sender that cannot complete the set before the last phase
    function automatic logic [PID_W-1:0] finish_source();
        int unsigned lo;
        lo = (cur_pc > MAX_PROCS) ? MAX_PROCS : cur_pc;
        if (lo >= MAX_PROCS) begin
            lo = MAX_PROCS - 1;
        end
        return PID_W'($urandom_range(lo, MAX_PROCS - 1));
    endfunction

    // one command word, with a random hold-off before it
    task automatic send_word(input logic [2:0] op, input logic [CLOCK_BITS-1:0] stamp,
                             input logic [PID_W-1:0] src);
        int gap;
        if (gap_run == 0) begin
            no_gaps = ($urandom_range(0, 2) == 0);
            gap_run = $urandom_range(10, 60);
        end
        gap_run--;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start        <= 1'b1;
        i_opcode     <= op;
        i_msg_clock  <= stamp;
        i_msg_source <= src;
        @(posedge i_clk);
        while (busy !== 1'b0) begin
            @(posedge i_clk);
        end
        items_sent++;
        stamp_hint = stamp_hint + 1'b1;
    endtask

    task automatic shuffle_batch();
        int   i;
        int   j;
        t_cmd tmp;
        for (i = batch.size(); i > 1; i--) begin
            j = $urandom_range(0, i - 1);
            tmp        = batch[i-1];
            batch[i-1] = batch[j];
            batch[j]   = tmp;
        end
    endtask

    task automatic send_batch();
        foreach (batch[k]) begin
            send_word(batch[k].op, batch[k].stamp, batch[k].src);
        end
    endtask

    // wait until every result word is back and the node is quiet
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_W-1:0] pc, input logic [PID_W-1:0] rank);
        settle();
        write_reg(CFG_PROCESS_COUNT, pc);
        write_reg(CFG_OWN_RANK, CFG_W'(rank));
        cur_pc   = pc;
        cur_rank = rank;
        settings_used++;
    endtask

    // lock, own request and oks with other requests mixed in, then release
    task automatic mutex_round();
        int unsigned n_ok;
        int unsigned n_other;
        int unsigned i;
        logic [PID_W-1:0] others[$];
        n_ok    = (cur_pc > MAX_PROCS) ? MAX_PROCS : cur_pc;
        n_other = $urandom_range(0, 3);
        send_word(OP_LOCK, $urandom(), PID_W'($urandom()));
        batch.delete();
        batch.push_back('{OP_REQUIRE, stamp_hint, cur_rank});
        for (i = 0; i < n_ok; i++) begin
            batch.push_back('{OP_OK, pick_stamp(), PID_W'(i)});
        end
        for (i = 0; i < n_other; i++) begin
            others.push_back(PID_W'($urandom()));
            batch.push_back('{OP_REQUIRE, pick_stamp(), others[i]});
        end
        shuffle_batch();
        send_batch();
        send_word(OP_UNLOCK, $urandom(), PID_W'($urandom()));
        batch.delete();
        batch.push_back('{OP_RELEASE, pick_stamp(), cur_rank});
        foreach (others[k]) begin
            batch.push_back('{OP_RELEASE, pick_stamp(), others[k]});
        end
        shuffle_batch();
        send_batch();
    endtask

    // 12 to 20 requests, which can fill the queue, then each one released plus two random releases
    task automatic request_flood();
        int unsigned n;
        logic [PID_W-1:0] src;
        n = $urandom_range(12, 20);
        batch.delete();
        repeat (n) begin
            src = PID_W'($urandom());
            send_word(OP_REQUIRE, stamp_hint + $urandom_range(0, 3), src);
            batch.push_back('{OP_RELEASE, pick_stamp(), src});
        end
        repeat (2) begin
            batch.push_back('{OP_RELEASE, pick_stamp(), PID_W'($urandom())});
        end
        shuffle_batch();
        send_batch();
    endtask

    // unordered words of any code
    task automatic noise_burst();
        int unsigned n;
        logic [2:0] op;
        logic [PID_W-1:0] src;
        n = $urandom_range(1, 8);
        repeat (n) begin
            op  = 3'($urandom_range(0, 7));
            src = PID_W'($urandom());
            if (op == OP_FINISH) begin
                if (cur_pc == 0) begin
                    op = OP_SPARE;
                end else begin
                    src = finish_source();
                end
            end
            send_word(op, pick_stamp(), src);
        end
    endtask

    task automatic run_phase(input int count);
        int goal;
        goal = items_sent + count;
        while (items_sent < goal) begin
            case ($urandom_range(0, 7))
                0, 1, 2, 3: mutex_round();
                4:          request_flood();
                default:    noise_burst();
            endcase
        end
    endtask

    initial begin : stimulus
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_opcode      = '0;
        i_msg_clock   = '0;
        i_msg_source  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = 1'b0;
        i_cfg_data    = '0;
        stamp_hint    = 32'd1;
        wide_stamps   = 1'b0;
        gap_run       = 0;
        items_sent    = 0;
        settings_used = 0;
        idle_cycles   = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: three processes, this node is rank 1
        configure(5'd3, 4'd1);
        send_word(OP_SPARE, 32'd0, 4'd0);
        send_word(OP_LOCK, 32'hFFFF_FFFF, 4'd0);
        send_word(OP_REQUIRE, 32'd1, 4'd1);
        send_word(OP_REQUIRE, 32'd1, 4'd0);
        send_word(OP_REQUIRE, 32'd1, 4'd2);
        send_word(OP_OK, 32'd2, 4'd0);
        send_word(OP_OK, 32'd2, 4'd1);
        send_word(OP_OK, 32'd2, 4'd2);
        // lower pid leaves the head, own request takes it
        send_word(OP_RELEASE, 32'd3, 4'd0);
        send_word(OP_RELEASE, 32'd3, 4'd9);
        // stale request jumps ahead of us
        send_word(OP_REQUIRE, 32'd0, 4'd15);
        send_word(OP_OK, 32'd0, 4'd5);
        send_word(OP_RELEASE, 32'd4, 4'd15);
        send_word(OP_LOCK, 32'd0, 4'd0);
        send_word(OP_OK, 32'd9, 4'd0);
        send_word(OP_OK, 32'd9, 4'd2);
        send_word(OP_OK, 32'd9, 4'd1);
        send_word(OP_UNLOCK, 32'd0, 4'd0);
        send_word(OP_RELEASE, 32'd10, 4'd1);
        send_word(OP_RELEASE, 32'd10, 4'd2);
        send_word(OP_FINISH, 32'd11, 4'd7);
        send_word(OP_STOP, 32'd0, 4'd0);
        run_phase(300);

        configure(5'd16, 4'd15);
        run_phase(300);
        // count above the process limit
        configure(5'd31, 4'd0);
        run_phase(250);
        configure(5'd1, 4'd0);
        run_phase(250);
        configure(5'd5, 4'd4);
        run_phase(300);

        // full-width stamps, clock runs into saturation
        configure(5'd16, 4'd7);
        wide_stamps = 1'b1;
        send_word(OP_REQUIRE, 32'hFFFF_FFFE, 4'd7);
        send_word(OP_OK, 32'hFFFF_FFFF, 4'd0);
        send_word(OP_LOCK, 32'h8000_0000, 4'd15);
        send_word(OP_REQUIRE, 32'd0, 4'd3);
        send_word(OP_RELEASE, 32'd0, 4'd3);
        send_word(OP_RELEASE, 32'd0, 4'd7);
        run_phase(300);

        // zero processes: the first finish ends the session
        configure(5'd0, 4'd15);
        run_phase(150);
        send_word(OP_FINISH, pick_stamp(), 4'd9);
        send_word(OP_OK, pick_stamp(), 4'd9);

        // after finishing only local commands should act
        configure(5'd2, 4'd0);
        run_phase(80);

        settle();
        $display("run covered %0d command words over %0d node settings",
                 items_sent, settings_used);
        $display("%0d result words compared, %0d granted, %0d with queue overflow",
                 checked, grants, overflows);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/lmx_pkg.sv
rtl/lmx_cell.sv
rtl/lmx_queue.sv
rtl/lmx_top_dummy_placeholder.sv
rtl/lamport_mutex_node_core.sv
tb/lamport_mutex_node_core_checker.sv
tb/lamport_mutex_node_core_tb.sv
